@@ design/bsff_pkg.sv @@
// ----------------------------------------------------------------------------
// bsff_pkg: shared definitions for the bitmap set unit
// Request codes and default sizes used by the bitmap set modules.
// ----------------------------------------------------------------------------
package bsff_pkg;

    // default sizes
    localparam int CAPACITY_DEF  = 1024;
    localparam int WORD_BITS_DEF = 32;

    // request field widths
    localparam int REQ_W  = 3;
    localparam int ELEM_W = 16;
    localparam int MCNT_W = 11;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

endpackage

@@ design/bsff_ram.sv @@
// ----------------------------------------------------------------------------
// bsff_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bsff_scan.sv @@
// ----------------------------------------------------------------------------
// bsff_scan: lowest set bit finder for one bitmap word
// Masks bits below the start offset on the first word, then isolates the
// lowest remaining set bit and encodes its position.
// ----------------------------------------------------------------------------
module bsff_scan #(
    parameter int WORD_W = 32,
    localparam int BW = (WORD_W > 1) ? $clog2(WORD_W) : 1
) (
    input  logic [WORD_W-1:0] word,
    input  logic [BW-1:0]     offset,
    input  logic              first,
    output logic              hit,
    output logic [BW-1:0]     pos
);

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] low_bit;

    // drop bits below the start index on the first word only
    assign mask    = first ? ({WORD_W{1'b1}} << offset) : {WORD_W{1'b1}};
    assign masked  = word & mask;
    assign low_bit = masked & (~masked + {{(WORD_W-1){1'b0}}, 1'b1});
    assign hit     = |masked;

    // one-hot to binary
    always_comb begin
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low_bit[i]) begin
                pos = pos | BW'(i);
            end
        end
    end

endmodule

@@ design/bitmap_set_with_find_first_unit.sv @@
// Insert, erase, test and clear read the addressed ram word; insert and erase then
// write back the modified word, and the result is registered. Find-first reads the
// start word, then each following word until a set bit or the last word is reached.
// A request is taken only in idle, so a new one waits until the current one is
// done; a full result register holds every request back before its result loads.
// Reset and clear sweep the ram with zeros, one word a cycle, taking no request.
// ----------------------------------------------------------------------------
// bitmap_set_with_find_first_unit: membership bitmap with count and search
// Insert, erase, test, find-first and clear over a ram-held bitmap.
// ----------------------------------------------------------------------------
module bitmap_set_with_find_first_unit #(
    parameter int CAPACITY  = bsff_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = bsff_pkg::WORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tdata: element[15:0]
    input  logic [bsff_pkg::ELEM_W-1:0]  s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [bsff_pkg::REQ_W-1:0]   s_axis_tuser,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: status[0], hit[1], found_index[17:2], member_count[28:18],
    //        is_empty[29], zero pad[31:30]
    output logic [31:0]                  m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready
);

    import bsff_pkg::*;

    // word width rounded up to a power of two so that index split is a shift
    localparam int WW        = 1 << $clog2(WORD_BITS);
    localparam int BW        = $clog2(WW);
    localparam int NUM_WORDS = (CAPACITY + WW - 1) / WW;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    typedef enum logic [3:0] {
        ST_SWEEP = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_FIND  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic              range_reg, range_next;
    logic [AW-1:0]     word_reg, word_next;
    logic              first_reg, first_next;

    logic              m_valid_reg, m_valid_next;
    logic              status_reg, status_next;
    logic              hit_reg, hit_next;
    logic [ELEM_W-1:0] found_reg, found_next;
    logic [MCNT_W-1:0] mcount_reg, mcount_next;
    logic              empty_reg, empty_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_rdata;

    logic              scan_hit;
    logic [BW-1:0]     scan_pos;

    logic              slot_free;
    logic              load_out;
    logic [BW-1:0]     bit_off;
    logic [WW-1:0]     bit_mask;
    logic              bit_set;
    logic [CNT_W+MCNT_W-1:0] cnt_wide;

    bsff_ram #(
        .WIDTH (WW),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsff_scan #(
        .WORD_W (WW)
    ) u_scan (
        .word   (ram_rdata),
        .offset (bit_off),
        .first  (first_reg),
        .hit    (scan_hit),
        .pos    (scan_pos)
    );

    // request decode helpers
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign bit_off       = elem_reg[BW-1:0];
    assign bit_mask      = {{(WW-1){1'b0}}, 1'b1} << bit_off;
    assign bit_set       = ram_rdata[bit_off];
    assign cnt_wide      = {{MCNT_W{1'b0}}, count_next};

    // sequencer, memory access and result build
    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        elem_next   = elem_reg;
        range_next  = range_reg;
        word_next   = word_reg;
        first_next  = first_reg;
        ram_we      = 1'b0;
        ram_waddr   = word_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = word_reg;
        load_out    = 1'b0;
        status_next = status_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;

        case (state_reg)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
                if (sweep_reg == LAST_WORD) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    req_next   = s_axis_tuser;
                    elem_next  = s_axis_tdata;
                    range_next = ({1'b0, s_axis_tdata} < 17'(CAPACITY));
                    word_next  = AW'(s_axis_tdata >> BW);
                    first_next = 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(s_axis_tdata >> BW);
                    if (s_axis_tuser == REQ_FIND &&
                        ({1'b0, s_axis_tdata} < 17'(CAPACITY))) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    load_out    = 1'b1;
                    status_next = 1'b0;
                    hit_next    = 1'b0;
                    found_next  = '0;
                    state_next  = ST_IDLE;
                    case (req_reg)
                        REQ_INSERT: begin
                            if (!range_reg) begin
                                status_next = 1'b1;
                            end else if (!bit_set) begin
                                ram_we     = 1'b1;
                                ram_wdata  = ram_rdata | bit_mask;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_ERASE: begin
                            if (!range_reg) begin
                                status_next = 1'b1;
                            end else if (bit_set) begin
                                ram_we     = 1'b1;
                                ram_wdata  = ram_rdata & ~bit_mask;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        REQ_TEST: begin
                            hit_next = range_reg && bit_set;
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                            state_next = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (scan_hit || word_reg == LAST_WORD) begin
                    if (slot_free) begin
                        load_out    = 1'b1;
                        status_next = 1'b0;
                        hit_next    = scan_hit;
                        found_next  = scan_hit ? ELEM_W'({word_reg, scan_pos}) : '0;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = word_reg + 1'b1;
                    word_next  = word_reg + 1'b1;
                    first_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        mcount_next  = mcount_reg;
        empty_next   = empty_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            mcount_next  = cnt_wide[MCNT_W-1:0];
            empty_next   = (count_next == '0);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            sweep_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        elem_reg   <= elem_next;
        range_reg  <= range_next;
        word_reg   <= word_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        mcount_reg <= mcount_next;
        empty_reg  <= empty_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, empty_reg, mcount_reg, found_reg, hit_reg, status_reg};

endmodule
